@@ hw/rtl/hpst_pkg.sv @@
// Package for the hot page score table: sizes, commands, register indexes, cell types.
`default_nettype none
package hpst_pkg;
  localparam int Entries   = 64;
  localparam int IdxW      = $clog2(Entries);
  localparam int CntW      = $clog2(Entries + 1);
  localparam int PageW     = 52;
  localparam int ScoreW    = 32;
  localparam int RankW     = 6;
  localparam int OccW      = 7;
  localparam int CfgIdxW   = 2;

  typedef enum logic [1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_FORGET = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RANK   = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INS  = 2'd0,
    REG_INC  = 2'd1,
    REG_AGE  = 2'd2,
    REG_CEIL = 2'd3
  } reg_idx_t;

  // Per-cell action for one update.
  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_FROM_L = 3'd1,  // take left neighbor (shift toward cold end)
    ACT_FROM_R = 3'd2,  // take right neighbor (shift toward hot end)
    ACT_LOAD   = 3'd3,  // take the broadcast entry
    ACT_CLEAR  = 3'd4   // drop entry
  } act_t;

  typedef struct packed {
    logic              valid;
    logic [PageW-1:0]  page;
    logic [ScoreW-1:0] score;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              renorm;
    logic [ScoreW-1:0] glob;
    logic [PageW-1:0]  page;
    logic [ScoreW-1:0] score;
  } bcast_t;
endpackage
`default_nettype wire

@@ hw/rtl/hot_page_score_table.sv @@
// Top level of the hot page score table: controller and the row of slot cells.
// Hot page score table. Keeps up to Entries pages sorted hottest first in a row
// of slot cells; every cell compares its page and score against a broadcast in
// parallel, and an update moves entries one place to a neighbor.
// An item is taken at a rising edge with start high and busy low. busy then stays
// high through ST_MATCH (match and, for a touch, age: renormalize the cells if the
// global score nears overflow), ST_SCORE (score the touched or new entry) and
// ST_MOVE (pick the position, move or load the cells and capture the result). The
// out_valid strobe is registered from ST_MOVE, with busy already low, so a new item
// can be taken at the edge that ends the strobe. The result strobe lasts one cycle
// and the receiver cannot stall it. No clearing pass: the block is ready after reset.
`default_nettype none
module hot_page_score_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_command,
  input  wire logic [hpst_pkg::PageW-1:0]  in_page_id,
  input  wire logic [hpst_pkg::RankW-1:0]  in_rank,
  input  wire logic                        cfg_we,
  input  wire logic [hpst_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hpst_pkg::ScoreW-1:0] cfg_data,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [hpst_pkg::PageW-1:0]       out_page,
  output logic [hpst_pkg::ScoreW-1:0]      out_score,
  output logic [hpst_pkg::OccW-1:0]        out_occupancy
);
  import hpst_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_SCORE = 4'b0100,
    ST_MOVE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ScoreW-1:0] ins_r, inc_r, age_r, ceil_r, glob_r, glob_nxt;
  cmd_t              cmd_r;
  logic [PageW-1:0]  page_r;
  logic [RankW-1:0]  rank_r;
  logic              found_r;
  logic [IdxW-1:0]   fidx_r;
  logic [ScoreW-1:0] new_score_r;
  logic [CntW-1:0]   cnt_r;
  logic              out_valid_r, out_hit_r;
  logic [PageW-1:0]  out_page_r;
  logic [ScoreW-1:0] out_score_r;
  logic [OccW-1:0]   out_occ_r;

  entry_t ent    [Entries];
  logic   match  [Entries];
  logic   gt     [Entries];
  act_t   act    [Entries];
  bcast_t bc;

  // Count valid cells: they always form a prefix, so the boundary marks it.
  logic [CntW-1:0] cnt_w;
  always_comb begin
    cnt_w = '0;
    for (int i = 0; i < Entries; i++) begin
      if (ent[i].valid) cnt_w = CntW'(i + 1);
    end
  end

  // Match encoder and the score of the matching cell (pages are unique).
  logic              any_m;
  logic [IdxW-1:0]   midx;
  logic [ScoreW-1:0] mscore;
  always_comb begin
    any_m  = 1'b0;
    midx   = '0;
    mscore = '0;
    for (int i = 0; i < Entries; i++) begin
      if (match[i]) begin
        any_m  = 1'b1;
        midx   = IdxW'(i);
        mscore = ent[i].score;
      end
    end
  end

  // Cells a new page competes with: a full table drops its coldest entry first.
  logic [CntW-1:0] cnt_ins;
  assign cnt_ins = (cnt_r == CntW'(Entries)) ? CntW'(Entries - 1) : cnt_r;

  // Insert position: first cell not strictly above the new score. After wrap the
  // order may break, so take the first such cell, not a thermometer count.
  logic [CntW-1:0] first_le;
  always_comb begin
    first_le = cnt_ins;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (CntW'(i) < cnt_ins && !gt[i]) first_le = CntW'(i);
    end
  end

  // Move-up target: just behind the nearest predecessor strictly above the new
  // score, or the hot end when there is none.
  logic [IdxW-1:0] up_pos;
  always_comb begin
    up_pos = '0;
    for (int i = 0; i < Entries; i++) begin
      if (IdxW'(i) < fidx_r && gt[i]) up_pos = IdxW'(i + 1);
    end
  end

  // Aging: rise and renormalize check.
  logic [ScoreW-1:0] glob_up;
  logic              renorm_w;
  assign glob_up  = glob_r + age_r;
  assign renorm_w = !(glob_up < ~age_r) || !(glob_up < ~ceil_r);

  // Touched score: glob_r already holds the aged global score in ST_SCORE and the
  // cells already hold renormalized scores.
  logic [ScoreW-1:0] ceil_v, add_v, touched;
  assign ceil_v  = glob_r + ceil_r;
  assign add_v   = inc_r + age_r;
  assign touched = (ceil_v > add_v && mscore > ceil_v - add_v) ? ceil_v : mscore + add_v;

  logic renorm_now;
  assign renorm_now = (state_r == ST_MATCH) && (cmd_r == CMD_TOUCH) && renorm_w;

  always_comb begin
    bc.renorm = renorm_now;
    bc.glob   = glob_up;
    bc.page   = page_r;
    bc.score  = new_score_r;
  end

  // Score computed in ST_SCORE: new entry score or touched score.
  logic [ScoreW-1:0] score_calc;
  assign score_calc = found_r ? touched : glob_r + ins_r;

  logic [IdxW-1:0] pos_w;
  assign pos_w = found_r ? up_pos : first_le[IdxW-1:0];

  // Cell actions in ST_MOVE.
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      act[i] = ACT_HOLD;
      if (state_r == ST_MOVE) begin
        if (cmd_r == CMD_FORGET && found_r) begin
          if (IdxW'(i) >= fidx_r) act[i] = (i == Entries - 1) ? ACT_CLEAR : ACT_FROM_R;
        end else if (cmd_r == CMD_TOUCH && found_r) begin
          if (IdxW'(i) == pos_w) act[i] = ACT_LOAD;
          else if (IdxW'(i) > pos_w && IdxW'(i) <= fidx_r) act[i] = ACT_FROM_L;
        end else if (cmd_r == CMD_TOUCH) begin
          // Shift toward the cold end; on a full table the coldest falls off.
          if (IdxW'(i) == pos_w) act[i] = ACT_LOAD;
          else if (IdxW'(i) > pos_w) act[i] = ACT_FROM_L;
        end
      end
    end
  end

  for (genvar g = 0; g < Entries; g++) begin : g_cell
    entry_t l_in, r_in;
    if (g == 0) begin : g_l
      assign l_in = '0;
    end else begin : g_lc
      assign l_in = ent[g-1];
    end
    if (g == Entries - 1) begin : g_r
      assign r_in = '0;
    end else begin : g_rc
      assign r_in = ent[g+1];
    end
    hpst_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .bc     (bc),
      .act    (act[g]),
      .left_i (l_in),
      .right_i(r_in),
      .ent_o  (ent[g]),
      .match_o(match[g]),
      .gt_o   (gt[g])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_SCORE;
      ST_SCORE: state_nxt = ST_MOVE;
      ST_MOVE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign glob_nxt = renorm_now ? '0 : ((state_r == ST_MATCH && cmd_r == CMD_TOUCH) ?
                    glob_up : glob_r);

  // Rank read: the result register holds the selected cell.
  entry_t rank_ent;
  assign rank_ent = ent[rank_r];
  logic rank_in;
  assign rank_in = (CntW'(rank_r) < cnt_r);

  logic [CntW-1:0] occ_after;
  always_comb begin
    occ_after = cnt_r;
    if (cmd_r == CMD_FORGET && found_r) occ_after = cnt_r - 1'b1;
    else if (cmd_r == CMD_TOUCH && !found_r && cnt_r != CntW'(Entries)) occ_after = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      glob_r      <= '0;
      ins_r       <= '0;
      inc_r       <= 32'd8;
      age_r       <= 32'd1;
      ceil_r      <= 32'd1024;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      glob_r      <= glob_nxt;
      out_valid_r <= (state_r == ST_MOVE);
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_INS:  ins_r  <= cfg_data;
          REG_INC:  inc_r  <= cfg_data;
          REG_AGE:  age_r  <= cfg_data;
          REG_CEIL: ceil_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload pipeline: capture, match, score, move and report.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cmd_r  <= cmd_t'(in_command);
        page_r <= in_page_id;
        rank_r <= in_rank;
      end
      ST_MATCH: begin
        found_r <= any_m;
        fidx_r  <= midx;
        cnt_r   <= cnt_w;
      end
      ST_SCORE: begin
        new_score_r <= score_calc;
      end
      ST_MOVE: begin
        // Cells still hold their pre-move contents in this cycle.
        out_hit_r   <= (cmd_r == CMD_RANK) ? rank_in : found_r;
        out_page_r  <= (cmd_r == CMD_RANK) ? (rank_in ? rank_ent.page : '0) : page_r;
        out_score_r <= (cmd_r == CMD_RANK) ? (rank_in ? rank_ent.score : '0) :
                       (cmd_r == CMD_TOUCH) ? new_score_r : (found_r ? mscore : '0);
        out_occ_r   <= OccW'(occ_after);
      end
      default: ;
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_page      = out_page_r;
  assign out_score     = out_score_r;
  assign out_occupancy = out_occ_r;

  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy did not rise on accept");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("result strobe longer than one cycle");
  a_four: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##3 out_valid) else $error("result not on fourth cycle");
endmodule
`default_nettype wire

@@ hw/rtl/hpst_cell.sv @@
// One slot of the table: holds an entry, compares it and moves it to a neighbor.
`default_nettype none
module hpst_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hpst_pkg::bcast_t bc,
  input  wire hpst_pkg::act_t  act,
  input  wire hpst_pkg::entry_t left_i,
  input  wire hpst_pkg::entry_t right_i,
  output hpst_pkg::entry_t     ent_o,
  output logic                 match_o,
  output logic                 gt_o
);
  import hpst_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;

  assign ent_o   = '{valid: valid_r, page: ent_r.page, score: ent_r.score};
  assign match_o = valid_r && (ent_r.page == bc.page);
  assign gt_o    = valid_r && (ent_r.score > bc.score);

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    unique case (act)
      ACT_HOLD: begin
        if (bc.renorm) begin
          ent_nxt.score = (ent_r.score < bc.glob) ? '0 : ent_r.score - bc.glob;
        end
      end
      ACT_FROM_L: begin
        ent_nxt   = left_i;
        valid_nxt = left_i.valid;
      end
      ACT_FROM_R: begin
        ent_nxt   = right_i;
        valid_nxt = right_i.valid;
      end
      ACT_LOAD: begin
        ent_nxt.page  = bc.page;
        ent_nxt.score = bc.score;
        valid_nxt     = 1'b1;
      end
      ACT_CLEAR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end
endmodule
`default_nettype wire
